@@ hw/rtl/fkmnd_pkg.sv @@
// Package for the keypoint match / new-detect block.
// Holds field widths, register indexes and controller-datapath structs.
// Depends on nothing; used by every module of the block.
package fkmnd_pkg;

    localparam int FKMND_MAX_POINTS = 64;
    localparam int COORD_W          = 16;
    localparam int POINT_W          = 3 * COORD_W;
    localparam int TOL_W            = 16;
    localparam int STEP_W           = 17;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_X_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd3;

    localparam logic [TOL_W-1:0]         X_TOL_RESET    = 16'd1600;
    localparam logic [TOL_W-1:0]         SIZE_TOL_RESET = 16'd480;
    localparam logic signed [STEP_W-1:0] MIN_STEP_RESET = 17'sd0;
    localparam logic signed [STEP_W-1:0] MAX_STEP_RESET = 17'sd3200;
    localparam logic signed [STEP_W-1:0] FORWARD_LIMIT  = -17'sd80;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } fkmnd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } fkmnd_status_t;

endpackage

@@ hw/rtl/frame_keypoint_match_new_detect.sv @@
// Top level of the keypoint match / new-detect block.
// Instantiates fkmnd_ctrl and fkmnd_datapath; uses fkmnd_pkg.
//
// Input stream: one keypoint per transfer, tdata = {size, y, x} (x lowest),
// tuser = kind (1 marks an empty frame), tlast ends the frame. Output stream:
// one result per input transfer, tdata = {size, y, x}, tuser = {dropped,
// is_new}, tlast = frame done. Configuration: cfg_we, cfg_index, cfg_wdata,
// written only while the block is idle (a duty of the user; the block does not enforce it).
// An item passes from accept through a scan of the N points of the previous frame
// (N at most MAX_POINTS) through the single read port of the point memory, which
// stops at the first match, to a hand-off that loads the result register. An
// empty-frame marker goes from accept straight to hand-off, with no scan.
// The result appears on the output in the cycle after hand-off; the next item
// is accepted straight after, while the result still waits.
// Reset clears counts and handshake state and sets configuration to its reset values;
// memory contents need no clearing. If the receiver stalls, one result waits in the
// output register and the block holds the following item before its hand-off.
module frame_keypoint_match_new_detect #(
    parameter int MAX_POINTS = fkmnd_pkg::FKMND_MAX_POINTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fkmnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fkmnd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fkmnd_pkg::POINT_W-1:0]    s_axis_tdata,  // x, y, size
    input  logic                             s_axis_tuser,  // kind
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fkmnd_pkg::POINT_W-1:0]    m_axis_tdata,  // new_x, new_y, new_size
    output logic [1:0]                       m_axis_tuser,  // is_new, dropped
    output logic                             m_axis_tlast
);
    import fkmnd_pkg::*;

    fkmnd_cmd_t    cmd;
    fkmnd_status_t status;
    logic          out_is_new;
    logic          out_dropped;

    fkmnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fkmnd_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_kind        (s_axis_tuser),
        .in_point       (s_axis_tdata),
        .in_last        (s_axis_tlast),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_is_new     (out_is_new),
        .out_dropped    (out_dropped),
        .out_point      (m_axis_tdata),
        .out_frame_done (m_axis_tlast)
    );

    assign m_axis_tuser = {out_dropped, out_is_new};

endmodule

@@ hw/rtl/fkmnd_ctrl.sv @@
// Controller state machine of the keypoint match / new-detect block.
// Sequences accept, previous-frame scan and result hand-off.
// Depends on fkmnd_pkg for the command and status structs.
module fkmnd_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_kind,
    output logic                    in_ready,
    output fkmnd_pkg::fkmnd_cmd_t    cmd,
    input  fkmnd_pkg::fkmnd_status_t status
);
    import fkmnd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_kind ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/fkmnd_datapath.sv @@
// Datapath of the keypoint match / new-detect block: configuration registers,
// two-bank point memory, scan pipeline with match compare, result register.
// Depends on fkmnd_pkg; driven by fkmnd_ctrl through command and status.
module fkmnd_datapath #(
    parameter int MAX_POINTS = fkmnd_pkg::FKMND_MAX_POINTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fkmnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fkmnd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              in_kind,
    input  logic [fkmnd_pkg::POINT_W-1:0]     in_point,
    input  logic                              in_last,
    input  fkmnd_pkg::fkmnd_cmd_t             cmd,
    output fkmnd_pkg::fkmnd_status_t          status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_is_new,
    output logic                              out_dropped,
    output logic [fkmnd_pkg::POINT_W-1:0]     out_point,
    output logic                              out_frame_done
);
    import fkmnd_pkg::*;

    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = POINT_W + 1;

    logic [TOL_W-1:0]         x_tol_reg;
    logic [TOL_W-1:0]         size_tol_reg;
    logic signed [STEP_W-1:0] min_step_reg;
    logic signed [STEP_W-1:0] max_step_reg;

    logic [EW-1:0] mem [0:DEPTH-1];

    logic                 kind_reg;
    logic [POINT_W-1:0]   point_reg;
    logic                 last_reg;
    logic                 drop_reg;
    logic                 matched_reg;
    logic                 bank_reg;
    logic [CW-1:0]        cur_count_reg;
    logic [CW-1:0]        prev_count_reg;
    logic [CW-1:0]        rd_idx_reg;
    logic                 rd_valid_reg;
    logic [IW-1:0]        rd_pos_reg;
    logic [EW-1:0]        rd_data_reg;
    logic                 out_valid_reg;
    logic                 out_is_new_reg;
    logic                 out_dropped_reg;
    logic [POINT_W-1:0]   out_point_reg;
    logic                 out_frame_done_reg;

    logic                 full;
    logic                 store;
    logic                 issue;
    logic                 hit;
    logic                 end_frame;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [EW-1:0]        mem_wdata;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [COORD_W-1:0]   ps;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [COORD_W-1:0]   cs;
    logic [COORD_W-1:0]   dx_abs;
    logic [COORD_W-1:0]   ds_abs;
    logic signed [STEP_W-1:0] dy;

    assign full  = (cur_count_reg == CW'(MAX_POINTS));
    assign store = cmd.load && !in_kind && !full;
    assign issue = cmd.scan && !hit && (rd_idx_reg < prev_count_reg);

    assign cx = point_reg[COORD_W-1:0];
    assign cy = point_reg[2*COORD_W-1:COORD_W];
    assign cs = point_reg[3*COORD_W-1:2*COORD_W];
    assign px = rd_data_reg[COORD_W-1:0];
    assign py = rd_data_reg[2*COORD_W-1:COORD_W];
    assign ps = rd_data_reg[3*COORD_W-1:2*COORD_W];

    assign dx_abs = (cx >= px) ? (cx - px) : (px - cx);
    assign ds_abs = (cs >= ps) ? (cs - ps) : (ps - cs);
    assign dy     = $signed({1'b0, cy}) - $signed({1'b0, py});

    assign hit = rd_valid_reg && !rd_data_reg[EW-1]
                 && (dy > FORWARD_LIMIT)
                 && (dx_abs < x_tol_reg)
                 && (ds_abs < size_tol_reg)
                 && (dy < max_step_reg)
                 && (dy >= min_step_reg);

    assign status.scan_done = hit || (rd_idx_reg >= prev_count_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign end_frame = cmd.finish && (kind_reg || last_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {bank_reg, cur_count_reg[IW-1:0]};
        mem_wdata = {1'b0, in_point};
        if (store)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scan && hit)
        begin
            mem_we    = 1'b1;
            mem_waddr = {!bank_reg, rd_pos_reg};
            mem_wdata = {1'b1, rd_data_reg[POINT_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{!bank_reg, rd_idx_reg[IW-1:0]}];
            rd_pos_reg  <= rd_idx_reg[IW-1:0];
        end
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            point_reg <= in_point;
            last_reg  <= in_last;
            drop_reg  <= !in_kind && full;
        end
        if (cmd.finish)
        begin
            out_is_new_reg     <= !kind_reg && !matched_reg;
            out_dropped_reg    <= !kind_reg && drop_reg;
            out_point_reg      <= kind_reg ? '0 : point_reg;
            out_frame_done_reg <= kind_reg || last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_tol_reg      <= X_TOL_RESET;
            size_tol_reg   <= SIZE_TOL_RESET;
            min_step_reg   <= MIN_STEP_RESET;
            max_step_reg   <= MAX_STEP_RESET;
            matched_reg    <= 1'b0;
            bank_reg       <= 1'b0;
            cur_count_reg  <= '0;
            prev_count_reg <= '0;
            rd_idx_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_TOL:    x_tol_reg    <= cfg_wdata[TOL_W-1:0];
                    CFG_SIZE_TOL: size_tol_reg <= cfg_wdata[TOL_W-1:0];
                    CFG_MIN_STEP: min_step_reg <= $signed(cfg_wdata[STEP_W-1:0]);
                    CFG_MAX_STEP: max_step_reg <= $signed(cfg_wdata[STEP_W-1:0]);
                    default:      x_tol_reg    <= x_tol_reg;
                endcase
            end

            rd_valid_reg <= issue;
            if (cmd.load)
            begin
                matched_reg <= 1'b0;
                rd_idx_reg  <= '0;
            end
            else if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.scan && hit)
            begin
                matched_reg <= 1'b1;
            end

            if (store)
            begin
                cur_count_reg <= cur_count_reg + 1'b1;
            end
            else if (end_frame)
            begin
                cur_count_reg  <= '0;
                prev_count_reg <= cur_count_reg;
                bank_reg       <= !bank_reg;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_is_new     = out_is_new_reg;
    assign out_dropped    = out_dropped_reg;
    assign out_point      = out_point_reg;
    assign out_frame_done = out_frame_done_reg;

    a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> cmd.scan)
        else $error("read data pending outside scan");

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (CW'(rd_pos_reg) < prev_count_reg))
        else $error("scan read beyond previous frame");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_count_reg <= CW'(MAX_POINTS)) && (prev_count_reg <= CW'(MAX_POINTS)))
        else $error("frame count beyond capacity");

    a_frame_swap: assert property (@(posedge clk) disable iff (!rst_n)
        end_frame |=> (cur_count_reg == '0) && (bank_reg != $past(bank_reg)))
        else $error("frame end did not swap banks");

endmodule
